>>> rtl/system_tick_timer_defines.svh
// Assertion macros used by the system tick timer RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef SYSTEM_TICK_TIMER_DEFINES_SVH
`define SYSTEM_TICK_TIMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("system_tick_timer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("system_tick_timer: next-cycle check failed");

`endif

>>> rtl/stt_pkg.sv
// Package for the system tick timer: constants, codes and item types.
// Used by every module of the block; depends on nothing.
package stt_pkg;

	localparam int COUNTER_BITS = 24;
	localparam int SLOW_DIVIDE = 8;
	localparam int PRE_W = (SLOW_DIVIDE > 1) ? $clog2(SLOW_DIVIDE) : 1;
	localparam int CALIB_W = 24;
	localparam int DATA_W = 32;
	localparam int WRAP_W = 64;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} stt_op_t;

	typedef enum logic [1:0] {
		SEL_CTRL   = 2'd0,
		SEL_RELOAD = 2'd1,
		SEL_CURR   = 2'd2,
		SEL_CALIB  = 2'd3
	} stt_sel_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TEN_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INEXACT = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [1:0]        reg_select;
		logic [DATA_W-1:0] write_data;
	} stt_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              tick_interrupt;
		logic [WRAP_W-1:0] wrap_total;
	} stt_out_t;

endpackage

>>> rtl/stt_in_reg.sv
// Input register of the system tick timer: holds one accepted item.
// Depends on stt_pkg.
module stt_in_reg import stt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  stt_in_t in_item,
	input  logic    adv,
	output logic    valid_s1,
	output stt_in_t item_s1
);

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/stt_core.sv
// Timer state and per-item update: counter, prescaler, flags, wrap count.
// Depends on stt_pkg and system_tick_timer_defines.svh.
`include "system_tick_timer_defines.svh"

module stt_core import stt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  stt_in_t              item_s1,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output stt_out_t             res_d
);

	localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(SLOW_DIVIDE - 1);

	logic                    ce_q, ie_q, fs_q, flag_q;
	logic [COUNTER_BITS-1:0] reload_q, cnt_q;
	logic [PRE_W-1:0]        pre_q;
	logic [WRAP_W-1:0]       wrap_q;
	logic [CALIB_W-1:0]      ten_ms_q;
	logic                    no_ref_q, inexact_q;

	logic                    ce_d, ie_d, fs_d, flag_d;
	logic [COUNTER_BITS-1:0] reload_d, cnt_d;
	logic [PRE_W-1:0]        pre_d;
	logic [WRAP_W-1:0]       wrap_d;
	logic [DATA_W-1:0]       rd;
	logic                    irq, step;

	always_comb begin
		ce_d = ce_q;
		ie_d = ie_q;
		fs_d = fs_q;
		flag_d = flag_q;
		reload_d = reload_q;
		cnt_d = cnt_q;
		pre_d = pre_q;
		wrap_d = wrap_q;
		rd = '0;
		irq = 1'b0;
		step = 1'b0;
		unique case (item_s1.opcode)
			OP_TICK: begin
				if (ce_q) begin
					if (fs_q) begin
						step = 1'b1;
					end else if (pre_q >= PRE_LAST) begin
						pre_d = '0;
						step = 1'b1;
					end else begin
						pre_d = pre_q + PRE_W'(1);
					end
					if (step) begin
						if (cnt_q == '0) begin
							cnt_d = reload_q;
						end else begin
							cnt_d = cnt_q - COUNTER_BITS'(1);
							if (cnt_q == COUNTER_BITS'(1)) begin
								flag_d = 1'b1;
								wrap_d = wrap_q + WRAP_W'(1);
								irq = ie_q;
							end
						end
					end
				end
			end
			OP_READ: begin
				unique case (item_s1.reg_select)
					SEL_CTRL: begin
						rd = {15'b0, flag_q, 13'b0, fs_q, ie_q, ce_q};
						flag_d = 1'b0;
					end
					SEL_RELOAD: rd = DATA_W'(reload_q);
					SEL_CURR:   rd = DATA_W'(cnt_q);
					SEL_CALIB:  rd = {no_ref_q, inexact_q, 6'b0, ten_ms_q};
				endcase
			end
			OP_WRITE: begin
				unique case (item_s1.reg_select)
					SEL_CTRL: begin
						ce_d = item_s1.write_data[0];
						ie_d = item_s1.write_data[1];
						fs_d = item_s1.write_data[2];
					end
					SEL_RELOAD: reload_d = item_s1.write_data[COUNTER_BITS-1:0];
					SEL_CURR: begin
						cnt_d = '0;
						flag_d = 1'b0;
					end
					SEL_CALIB: ;
				endcase
			end
			OP_NONE: ;
		endcase
		res_d.read_data = rd;
		res_d.tick_interrupt = irq;
		res_d.wrap_total = wrap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce_q <= 1'b0;
			ie_q <= 1'b0;
			fs_q <= 1'b0;
			flag_q <= 1'b0;
			reload_q <= '0;
			cnt_q <= '0;
			pre_q <= '0;
			wrap_q <= '0;
		end else if (adv) begin
			ce_q <= ce_d;
			ie_q <= ie_d;
			fs_q <= fs_d;
			flag_q <= flag_d;
			reload_q <= reload_d;
			cnt_q <= cnt_d;
			pre_q <= pre_d;
			wrap_q <= wrap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ten_ms_q <= '0;
			no_ref_q <= 1'b0;
			inexact_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TEN_MS) begin
				ten_ms_q <= cfg_data[CALIB_W-1:0];
			end
			if (cfg_index == CFG_NO_REF) begin
				no_ref_q <= cfg_data[0];
			end
			if (cfg_index == CFG_INEXACT) begin
				inexact_q <= cfg_data[0];
			end
		end
	end

	`STT_ASSERT_IMP(a_irq_needs_enable, clk, arst_n, adv && irq, ie_q && ce_q)
	`STT_ASSERT_NXT(a_irq_bumps_wrap, clk, arst_n, adv && irq,
		wrap_q == $past(wrap_q) + WRAP_W'(1) && flag_q)
	`STT_ASSERT_NXT(a_curr_write_clears, clk, arst_n,
		adv && item_s1.opcode == OP_WRITE && item_s1.reg_select == SEL_CURR,
		cnt_q == '0 && !flag_q)
	`STT_ASSERT_NXT(a_wrap_only_on_tick, clk, arst_n,
		!(adv && item_s1.opcode == OP_TICK), wrap_q == $past(wrap_q))

endmodule

>>> rtl/stt_out_reg.sv
// Result register of the system tick timer: holds one finished result item.
// Depends on stt_pkg.
module stt_out_reg import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  stt_out_t res_d,
	output logic     out_free,
	output logic     out_valid,
	input  logic     out_ready,
	output stt_out_t out_item
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= res_d;
		end
	end

endmodule

>>> rtl/system_tick_timer.sv
// System tick timer: each input item is registered in the input register, passes
// once through the state update and leaves from the result register; one item is
// taken every cycle when the output side keeps up.
// Reset (arst_n low) clears control, counter, prescaler, wrap count, flags and
// calibration registers at once; the input register starts empty, so in_ready is high.
// Depends on stt_pkg, stt_in_reg, stt_core and stt_out_reg.
module system_tick_timer import stt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stt_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output stt_out_t             out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic     valid_s1, out_free, adv;
	stt_in_t  item_s1;
	stt_out_t res_d;

	assign adv = valid_s1 && out_free;

	stt_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	stt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_s1   (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_d     (res_d)
	);

	stt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.res_d     (res_d),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
